// File: sv/teq_pkg.sv
// Shared types and constants for the timed event queue.
// No dependencies; every other file imports this package.
package teq_pkg;

  localparam int QueueDepthDefault = 16;

  typedef enum logic [2:0] {
    KIND_SCHEDULE = 3'd0,
    KIND_HAS_SEQ  = 3'd1,
    KIND_DEL_SEQ  = 3'd2,
    KIND_HAS_TYPE = 3'd3,
    KIND_DEL_TYPE = 3'd4
  } op_kind_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  event_kind;
    logic [31:0] seq_num;
    logic [30:0] delay_us;
    logic [63:0] now_time;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic        rejected;
    logic [4:0]  occupancy;
    logic        head_valid;
    logic [63:0] head_due;
    logic [31:0] head_seq;
    logic [7:0]  head_kind;
  } rsp_t;

  // Classified word handed from the front part to the back part.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  event_kind;
    logic [31:0] seq_num;
    logic [63:0] due;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } back_state_t;

endpackage

// File: sv/teq_front.sv
// Front part: takes a command word, works out the due time and queues it.
// Depends on teq_pkg.
module teq_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  teq_pkg::cmd_t cmd,
  output logic          busy,
  output logic          job_valid,
  output teq_pkg::job_t job,
  input  logic          job_take
);
  import teq_pkg::*;

  // Two-entry queue between the parts.
  job_t        slot [2];
  logic [1:0]  fill;
  logic        rd_ptr;
  logic        wr_ptr;
  logic        push;
  logic        pending;

  assign push      = start && !busy;
  assign busy      = (fill != 2'd0) || pending;
  assign job_valid = fill != 2'd0;
  assign job       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= 2'd0;
      rd_ptr  <= 1'b0;
      wr_ptr  <= 1'b0;
      pending <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr  <= ~wr_ptr;
        pending <= 1'b1;
      end else if (job_take) begin
        pending <= 1'b0;
      end
      if (job_take) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, job_take && job_valid};
    end
  end

  // pending is cleared via job_take when the back part takes the accepted word.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr].kind       <= cmd.kind;
      slot[wr_ptr].event_kind <= cmd.event_kind;
      slot[wr_ptr].seq_num    <= cmd.seq_num;
      slot[wr_ptr].due        <= cmd.now_time + {33'd0, cmd.delay_us};
    end
  end
endmodule

// File: sv/teq_back.sv
// Back part: walks the sorted table one entry a cycle to carry out a word.
// Depends on teq_pkg.
module teq_back #(
  parameter int QUEUE_DEPTH = teq_pkg::QueueDepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  teq_pkg::job_t job,
  output logic          job_take,
  output logic          done,
  output teq_pkg::rsp_t result
);
  import teq_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Table entries; shifted as a row, so each is a register at a fixed place.
  logic [63:0] due_r  [QUEUE_DEPTH];
  logic [31:0] seq_r  [QUEUE_DEPTH];
  logic [7:0]  kind_r [QUEUE_DEPTH];
  logic [CW-1:0] count;

  back_state_t state, state_next;
  job_t        cur;
  logic [CW-1:0] idx;
  logic        found;
  logic        rejected;
  logic [IW-1:0] pos;
  logic        hit;
  logic        at_end;
  logic        ins_now;

  assign pos    = idx[IW-1:0];
  assign at_end = idx >= count;

  always_comb begin
    hit = 1'b0;
    if (!at_end) begin
      case (cur.kind)
        KIND_HAS_SEQ, KIND_DEL_SEQ: hit = seq_r[pos] == cur.seq_num;
        KIND_HAS_TYPE, KIND_DEL_TYPE: hit = kind_r[pos] == cur.event_kind;
        default: hit = 1'b0;
      endcase
    end
    ins_now = (cur.kind == KIND_SCHEDULE) && (at_end || !(due_r[pos] < cur.due));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (job_valid) state_next = ST_WALK;
      ST_WALK: begin
        if (cur.kind == KIND_SCHEDULE) begin
          if (count == CW'(QUEUE_DEPTH) || ins_now) state_next = ST_DONE;
        end else if (at_end) state_next = ST_DONE;
        else if (hit && cur.kind != KIND_DEL_TYPE) state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    job_take = state == ST_IDLE && job_valid;
    done     = state == ST_DONE;
    result.found      = found;
    result.rejected   = rejected;
    result.occupancy  = 5'(count);
    result.head_valid = count != '0;
    result.head_due   = count != '0 ? due_r[0] : 64'd0;
    result.head_seq   = count != '0 ? seq_r[0] : 32'd0;
    result.head_kind  = count != '0 ? kind_r[0] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      idx      <= '0;
      found    <= 1'b0;
      rejected <= 1'b0;
    end else begin
      state <= state_next;
      if (job_take) begin
        cur      <= job;
        idx      <= '0;
        found    <= 1'b0;
        rejected <= 1'b0;
      end else if (state == ST_WALK) begin
        if (cur.kind == KIND_SCHEDULE) begin
          if (count == CW'(QUEUE_DEPTH)) rejected <= 1'b1;
          else if (ins_now) count <= count + 1'b1;
          else idx <= idx + 1'b1;
        end else if (!at_end) begin
          if (hit) found <= 1'b1;
          if (hit && (cur.kind == KIND_DEL_SEQ || cur.kind == KIND_DEL_TYPE))
            count <= count - 1'b1;
          else idx <= idx + 1'b1;
        end
      end
    end
  end

  // Row shifts: open a gap for insertion or close one after removal.
  always_ff @(posedge clk) begin
    if (state == ST_WALK && cur.kind == KIND_SCHEDULE &&
        count != CW'(QUEUE_DEPTH) && ins_now) begin
      for (int j = QUEUE_DEPTH - 1; j > 0; j--) begin
        if (IW'(j) > pos) begin
          due_r[j]  <= due_r[j-1];
          seq_r[j]  <= seq_r[j-1];
          kind_r[j] <= kind_r[j-1];
        end
      end
      due_r[pos]  <= cur.due;
      seq_r[pos]  <= cur.seq_num;
      kind_r[pos] <= cur.event_kind;
    end else if (state == ST_WALK && !at_end && hit &&
                 (cur.kind == KIND_DEL_SEQ || cur.kind == KIND_DEL_TYPE)) begin
      for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
        if (IW'(j) >= pos) begin
          due_r[j]  <= due_r[j+1];
          seq_r[j]  <= seq_r[j+1];
          kind_r[j] <= kind_r[j+1];
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH)) else $error("occupancy beyond depth");
  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    done && rejected |-> count == CW'(QUEUE_DEPTH)) else $error("reject while not full");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    job_take |=> state == ST_WALK) else $error("word taken without walk");
endmodule

// File: sv/timed_event_queue.sv
// Top level of the timed event queue: front part, queue and back part.
// Depends on teq_pkg, teq_front and teq_back.
//
//   channel   direction  handshake            word
//   command   in         start, busy          cmd (teq_pkg::cmd_t)
//   result    out        done strobe          result (teq_pkg::rsp_t)
//
// After acceptance a word waits in the queue until the back part takes it, then walks the
// table at one entry a cycle, and its result is strobed from the done state of the back part.
// A schedule stops at its slot p, at most the occupancy (a full table rejects it at the first
// step); delete-type and unmatched lookups walk all n entries plus one step at the end.
// Reset is synchronous and empties the table at once.
// busy is high from acceptance until the back part takes the word; a second word then
// waits in the queue until the walk ends. The receiver cannot stall.
module timed_event_queue #(
  parameter int QUEUE_DEPTH = teq_pkg::QueueDepthDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  teq_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output teq_pkg::rsp_t result
);
  import teq_pkg::*;

  logic job_valid;
  logic job_take;
  job_t job;

  teq_front u_front (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy),
    .job_valid(job_valid), .job(job), .job_take(job_take)
  );

  teq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job),
    .job_take(job_take), .done(done), .result(result)
  );
endmodule

// File: tb/timed_event_queue_test.sv
// Testbench for the timed event queue: directed table, then random command words.
// Depends on teq_pkg and timed_event_queue; holds its own model of the sorted table.
module timed_event_queue_test;
  import teq_pkg::*;

  localparam int Depth = 16;
  localparam int WatchLimit = 20000;

  typedef struct {
    cmd_t c;
    bit   chk;
    rsp_t r;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy, done;
  rsp_t result;

  timed_event_queue dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .result(result)
  );

  always #5 clk = ~clk;

  // Model of the table.
  logic [63:0] mdl_due[Depth];
  logic [31:0] mdl_seq[Depth];
  logic [7:0]  mdl_kind[Depth];
  int          mdl_count = 0;

  rsp_t pending_rsp[$];
  int   fails = 0;
  int   idle_cycles = 0;
  int   words_in = 0;
  int   words_out = 0;
  bit   calm = 0;

  // Directed rows carry an expected result; these are queued next to the prediction.
  bit   typed_chk[$];
  rsp_t typed_rsp[$];

  function automatic void drop_entry(int p);
    for (int j = p; j + 1 < mdl_count; j++) begin
      mdl_due[j] = mdl_due[j + 1];
      mdl_seq[j] = mdl_seq[j + 1];
      mdl_kind[j] = mdl_kind[j + 1];
    end
    mdl_count--;
  endfunction

  function automatic rsp_t apply_word(cmd_t c);
    rsp_t r;
    logic [63:0] due;
    int p;
    r = '0;
    case (c.kind)
      KIND_SCHEDULE: begin
        due = c.now_time + {33'd0, c.delay_us};
        if (mdl_count >= Depth) r.rejected = 1'b1;
        else begin
          p = 0;
          while (p < mdl_count && mdl_due[p] < due) p++;
          for (int j = mdl_count; j > p; j--) begin
            mdl_due[j] = mdl_due[j - 1];
            mdl_seq[j] = mdl_seq[j - 1];
            mdl_kind[j] = mdl_kind[j - 1];
          end
          mdl_due[p] = due;
          mdl_seq[p] = c.seq_num;
          mdl_kind[p] = c.event_kind;
          mdl_count++;
        end
      end
      KIND_HAS_SEQ, KIND_DEL_SEQ: begin
        for (p = 0; p < mdl_count; p++) if (mdl_seq[p] == c.seq_num) break;
        if (p < mdl_count) begin
          r.found = 1'b1;
          if (c.kind == KIND_DEL_SEQ) drop_entry(p);
        end
      end
      KIND_HAS_TYPE: begin
        for (p = 0; p < mdl_count; p++) if (mdl_kind[p] == c.event_kind) r.found = 1'b1;
      end
      KIND_DEL_TYPE: begin
        p = 0;
        while (p < mdl_count) begin
          if (mdl_kind[p] == c.event_kind) begin
            r.found = 1'b1;
            drop_entry(p);
          end else p++;
        end
      end
      default: ;
    endcase
    r.occupancy = mdl_count[4:0];
    if (mdl_count > 0) begin
      r.head_valid = 1'b1;
      r.head_due = mdl_due[0];
      r.head_seq = mdl_seq[0];
      r.head_kind = mdl_kind[0];
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  task automatic compare_rsp(rsp_t e, rsp_t a);
    compare_field("found", e.found, a.found);
    compare_field("rejected", e.rejected, a.rejected);
    compare_field("occupancy", e.occupancy, a.occupancy);
    compare_field("head_valid", e.head_valid, a.head_valid);
    compare_field("head_due", e.head_due, a.head_due);
    compare_field("head_seq", e.head_seq, a.head_seq);
    compare_field("head_kind", e.head_kind, a.head_kind);
  endtask

  // Result side: compare each strobed word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) idle_cycles <= 0;
      else if (done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        words_out++;
        if (pending_rsp.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          compare_rsp(pending_rsp.pop_front(), result);
          if (typed_chk.pop_front()) compare_rsp(typed_rsp.pop_front(), result);
          else void'(typed_rsp.pop_front());
        end
      end
      if (idle_cycles >= WatchLimit) begin
        $display("[timed_event_queue] ERROR");
        $finish;
      end
    end
  end

  // Present one word from a falling edge until it is accepted. start is left high
  // afterwards; it drops only for an idle burst or at the end of the run.
  task automatic send_word(cmd_t c, bit chk, rsp_t r);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      cmd <= '0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    pending_rsp.push_back(apply_word(c));
    typed_chk.push_back(chk);
    typed_rsp.push_back(r);
    words_in++;
    @(negedge clk);
  endtask

  function automatic cmd_t mk(logic [2:0] k, logic [7:0] ek, logic [31:0] sq,
                              logic [30:0] d, logic [63:0] now);
    cmd_t c;
    c.kind = k;
    c.event_kind = ek;
    c.seq_num = sq;
    c.delay_us = d;
    c.now_time = now;
    return c;
  endfunction

  function automatic rsp_t mkr(bit f, bit rj, int occ, bit hv, logic [63:0] hd,
                               logic [31:0] hs, logic [7:0] hk);
    rsp_t r;
    r.found = f;
    r.rejected = rj;
    r.occupancy = occ[4:0];
    r.head_valid = hv;
    r.head_due = hd;
    r.head_seq = hs;
    r.head_kind = hk;
    return r;
  endfunction

  // Random word: small pools of types and sequence numbers so lookups hit.
  function automatic cmd_t rand_word();
    cmd_t c;
    int sel;
    c.kind = 3'($urandom_range(0, 4));
    sel = $urandom_range(0, 9);
    if (sel == 0) c.kind = 3'($urandom_range(5, 7));
    if (mdl_count < 10 && $urandom_range(0, 2) == 0) c.kind = KIND_SCHEDULE;
    c.event_kind = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    c.seq_num = ($urandom_range(0, 4) == 0) ? 32'($urandom) : 32'($urandom_range(0, 15));
    c.delay_us = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 20));
    case ($urandom_range(0, 3))
      0: c.now_time = {$urandom, $urandom};
      1: c.now_time = 64'hFFFF_FFFF_FFFF_FFF0 + 64'($urandom_range(0, 15));
      default: c.now_time = 64'($urandom_range(0, 40));
    endcase
    return c;
  endfunction

  vec_t table_rows[$];
  rsp_t nil;

  initial begin
    nil = '0;
    // Empty table queries, then schedule extremes, equal times, wrap, full, deletes.
    table_rows.push_back('{mk(KIND_HAS_SEQ, 8'd0, 32'd0, 31'd0, 64'd0), 1, nil});
    table_rows.push_back('{mk(KIND_DEL_TYPE, 8'hFF, 32'd0, 31'd0, 64'd0), 1, nil});
    table_rows.push_back('{mk(3'd7, 8'hFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, '1), 1, nil});
    table_rows.push_back('{mk(KIND_SCHEDULE, 8'hFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
      64'hFFFF_FFFF_FFFF_FFFF), 1,
      mkr(0, 0, 1, 1, 64'h0000_0000_7FFF_FFFE, 32'hFFFF_FFFF, 8'hFF)});
    table_rows.push_back('{mk(KIND_SCHEDULE, 8'h00, 32'd0, 31'd0, 64'd0), 1,
      mkr(0, 0, 2, 1, 64'd0, 32'd0, 8'd0)});
    table_rows.push_back('{mk(KIND_SCHEDULE, 8'h05, 32'd1, 31'd0, 64'd0), 1,
      mkr(0, 0, 3, 1, 64'd0, 32'd1, 8'd5)});
    for (int i = 0; i < 14; i++)
      table_rows.push_back('{mk(KIND_SCHEDULE, 8'(i % 3), 32'(i % 4), 31'(i), 64'd100),
                            0, nil});
    table_rows.push_back('{mk(KIND_HAS_TYPE, 8'd5, 32'd0, 31'd0, 64'd0), 0, nil});
    table_rows.push_back('{mk(KIND_DEL_SEQ, 8'd0, 32'd1, 31'd0, 64'd0), 0, nil});
    table_rows.push_back('{mk(KIND_DEL_TYPE, 8'd1, 32'd0, 31'd0, 64'd0), 0, nil});
    table_rows.push_back('{mk(KIND_HAS_SEQ, 8'd0, 32'd3, 31'd0, 64'd0), 0, nil});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) send_word(table_rows[i].c, table_rows[i].chk, table_rows[i].r);
    for (int n = 0; n < 1800; n++) begin
      calm = (n >= 1600);
      send_word(rand_word(), 0, nil);
    end
    start <= 1'b0;
    cmd <= '0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pending_rsp.size() != 0) fails++;
    $display("Sent %0d command words, checked %0d result words across all five kinds.",
             words_in, words_out);
    if (fails == 0) $display("[timed_event_queue] OK");
    else $display("[timed_event_queue] ERROR");
    $finish;
  end

endmodule
